>>> rtl/bcl_pkg.sv
`timescale 1ns / 1ps
package bcl_pkg;

   localparam int unsigned VERT_W    = 9;
   localparam int unsigned MAX_VERTS = 256;
   localparam int unsigned VSLOTS    = MAX_VERTS + 1;
   localparam int unsigned STACK_W   = 8;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RUN   = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] REG_VC_ADDR = 2'd0;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [VERT_W-1:0] vertex_a;
      logic [VERT_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [VERT_W-1:0] answer;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_RD,
      S_ADD_WR,
      S_QRY,
      S_RUN_CLR,
      S_RUN_INIT,
      S_RUN_HEAD,
      S_LOOP,
      S_NBR,
      S_CHK,
      S_FINISH,
      S_POP_RD,
      S_POP_WR,
      S_RET,
      S_RET_WAIT,
      S_DONE
   } state_type;

endpackage

>>> rtl/bridge_component_labeler.sv
`timescale 1ns / 1ps
// Channel   Ports                            Direction  Moves
// request   req_valid, req_stall, req_data   in         cmd, vertex_a, vertex_b
// response  rsp_valid, rsp_stall, rsp_data   out        answer, status
// csr       csr_psel .. csr_pready           in/out     vertex_count at byte 0
//
// A run first clears the stamp and label stores, then walks the adjacency entries from
// vertex 1 (the entry back to the parent is skipped), reaching and labeling vertices; the
// stamp, label and stack memories are stepped by one sequencer around one shared compare
// unit.
// Reset is synchronous: graph empty, labels read 0, vertex_count 256.
// A new word is taken only in idle; a stalled response holds in its output register.
module bridge_component_labeler #(
   parameter int unsigned MAX_EDGES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bcl_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bcl_pkg::rsp_type    rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [1:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int unsigned VW          = bcl_pkg::VERT_W;
   localparam int unsigned SW          = bcl_pkg::STACK_W;
   localparam int unsigned ENTRY_SLOTS = 2 * MAX_EDGES;
   localparam int unsigned ENTRY_W     = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
   localparam int unsigned CNT_W       = $clog2(ENTRY_SLOTS + 1);
   localparam int unsigned CUR_W       = ENTRY_W + 1;
   localparam logic [CUR_W-1:0] NIL    = {1'b1, {ENTRY_W{1'b0}}};

   typedef struct packed {
      logic [VW-1:0]    v;
      logic [VW-1:0]    par;
      logic [CUR_W-1:0] cursor;
      logic [VW-1:0]    low;
      logic [VW-1:0]    disc;
      logic [VW-1:0]    pidx;
   } frame_type;

   // configuration
   logic [VW-1:0] vc_ff;
   logic          csr_wr;
   logic [VW-1:0] n_used;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr == bcl_pkg::REG_VC_ADDR) ? {{(32-VW){1'b0}}, vc_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VW'(bcl_pkg::MAX_VERTS);
      end else if (csr_wr) begin
         vc_ff <= csr_pwdata[VW-1:0];
      end
   end

   always_comb begin
      if (vc_ff == '0) begin
         n_used = VW'(1);
      end else if (vc_ff > VW'(bcl_pkg::MAX_VERTS)) begin
         n_used = VW'(bcl_pkg::MAX_VERTS);
      end else begin
         n_used = vc_ff;
      end
   end

   // memories
   logic [VW-1:0]      nbr_mem_ff  [ENTRY_SLOTS];
   logic [CUR_W-1:0]   nxt_mem_ff  [ENTRY_SLOTS];
   logic [ENTRY_W-1:0] head_mem_ff [bcl_pkg::VSLOTS];
   logic [ENTRY_W-1:0] tail_mem_ff [bcl_pkg::VSLOTS];
   logic [VW-1:0]      disc_mem_ff [bcl_pkg::VSLOTS];
   logic [VW-1:0]      lab_mem_ff  [bcl_pkg::VSLOTS];
   logic [VW-1:0]      pend_mem_ff [bcl_pkg::MAX_VERTS];
   frame_type          stk_mem_ff  [bcl_pkg::MAX_VERTS];

   logic [VW-1:0]      nbr_rd_ff;
   logic [CUR_W-1:0]   nxt_rd_ff;
   logic [ENTRY_W-1:0] head_rd_ff, tail_rd_ff;
   logic [VW-1:0]      disc_rd_ff, lab_rd_ff, pend_rd_ff;
   frame_type          stk_rd_ff;

   logic               nbr_we, nxt_we, head_we, tail_we, disc_we, lab_we, pend_we, stk_we;
   logic [ENTRY_W-1:0] nbr_wa, nxt_wa, ent_ra;
   logic [VW-1:0]      nbr_wd;
   logic [CUR_W-1:0]   nxt_wd;
   logic [VW-1:0]      head_wa, head_ra, tail_wa, tail_ra;
   logic [ENTRY_W-1:0] head_wd, tail_wd;
   logic [VW-1:0]      disc_wa, disc_wd, disc_ra, lab_wa, lab_wd, lab_ra;
   logic [SW-1:0]      pend_wa, pend_ra, stk_wa, stk_ra;
   logic [VW-1:0]      pend_wd;
   frame_type          stk_wd;

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem_ff[nbr_wa] <= nbr_wd;
      end
      if (nxt_we) begin
         nxt_mem_ff[nxt_wa] <= nxt_wd;
      end
      nbr_rd_ff <= nbr_mem_ff[ent_ra];
      nxt_rd_ff <= nxt_mem_ff[ent_ra];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem_ff[head_wa] <= head_wd;
      end
      if (tail_we) begin
         tail_mem_ff[tail_wa] <= tail_wd;
      end
      head_rd_ff <= head_mem_ff[head_ra];
      tail_rd_ff <= tail_mem_ff[tail_ra];
   end

   always_ff @(posedge clock) begin
      if (disc_we) begin
         disc_mem_ff[disc_wa] <= disc_wd;
      end
      if (lab_we) begin
         lab_mem_ff[lab_wa] <= lab_wd;
      end
      disc_rd_ff <= disc_mem_ff[disc_ra];
      lab_rd_ff  <= lab_mem_ff[lab_ra];
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem_ff[pend_wa] <= pend_wd;
      end
      if (stk_we) begin
         stk_mem_ff[stk_wa] <= stk_wd;
      end
      pend_rd_ff <= pend_mem_ff[pend_ra];
      stk_rd_ff  <= stk_mem_ff[stk_ra];
   end

   // shared compare unit
   logic [VW-1:0] min_a, min_b, min_val;
   logic          min_eq;

   bcl_min_unit u_min (
      .op_a    (min_a),
      .op_b    (min_b),
      .min_val (min_val),
      .eq      (min_eq)
   );

   // sequencer
   bcl_pkg::state_type state_ff, state_in;
   logic                       side_ff, side_in, ran_ff, ran_in;
   logic [VW-1:0]              a_ff, a_in, b_ff, b_in, ans_ff, ans_in;
   logic [1:0]                 stat_ff, stat_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [VW-1:0]              depth_ff, depth_in, pend_ff, pend_in;
   logic [VW-1:0]              time_ff, time_in, comp_ff, comp_in, sweep_ff, sweep_in;
   logic [VW-1:0]              cur_v_ff, cur_v_in, cur_par_ff, cur_par_in;
   logic [CUR_W-1:0]           cur_cur_ff, cur_cur_in;
   logic [VW-1:0]              cur_low_ff, cur_low_in, cur_disc_ff, cur_disc_in;
   logic [VW-1:0]              cur_pidx_ff, cur_pidx_in, nb_ff, nb_in;
   logic [bcl_pkg::VSLOTS-1:0] hv_ff, hv_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   bcl_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic [VW-1:0]              owner, other;
   logic                       bad_a, bad_b, full;

   assign req_stall = (state_ff != bcl_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign bad_a = (req_data.vertex_a == '0) || (req_data.vertex_a > n_used);
   assign bad_b = (req_data.vertex_b == '0) || (req_data.vertex_b > n_used);
   assign full  = ({1'b0, cnt_ff} + (CNT_W+1)'(2)) > (CNT_W+1)'(ENTRY_SLOTS);
   assign owner = side_ff ? b_ff : a_ff;
   assign other = side_ff ? a_ff : b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcl_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         hv_ff        <= '0;
         cnt_ff       <= '0;
         ran_ff       <= 1'b0;
         depth_ff     <= '0;
         pend_ff      <= '0;
         time_ff      <= '0;
         comp_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hv_ff        <= hv_in;
         cnt_ff       <= cnt_in;
         ran_ff       <= ran_in;
         depth_ff     <= depth_in;
         pend_ff      <= pend_in;
         time_ff      <= time_in;
         comp_ff      <= comp_in;
      end
      side_ff     <= side_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      ans_ff      <= ans_in;
      stat_ff     <= stat_in;
      sweep_ff    <= sweep_in;
      cur_v_ff    <= cur_v_in;
      cur_par_ff  <= cur_par_in;
      cur_cur_ff  <= cur_cur_in;
      cur_low_ff  <= cur_low_in;
      cur_disc_ff <= cur_disc_in;
      cur_pidx_ff <= cur_pidx_in;
      nb_ff       <= nb_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      ran_in       = ran_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ans_in       = ans_ff;
      stat_in      = stat_ff;
      cnt_in       = cnt_ff;
      depth_in     = depth_ff;
      pend_in      = pend_ff;
      time_in      = time_ff;
      comp_in      = comp_ff;
      sweep_in     = sweep_ff;
      cur_v_in     = cur_v_ff;
      cur_par_in   = cur_par_ff;
      cur_cur_in   = cur_cur_ff;
      cur_low_in   = cur_low_ff;
      cur_disc_in  = cur_disc_ff;
      cur_pidx_in  = cur_pidx_ff;
      nb_in        = nb_ff;
      hv_in        = hv_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      nbr_we = 1'b0; nbr_wa = '0; nbr_wd = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
      ent_ra = cur_cur_ff[ENTRY_W-1:0];
      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
      tail_we = 1'b0; tail_wa = '0; tail_wd = '0; tail_ra = '0;
      disc_we = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = '0;
      lab_we  = 1'b0; lab_wa  = '0; lab_wd  = '0; lab_ra  = '0;
      pend_we = 1'b0; pend_wa = '0; pend_wd = '0; pend_ra = '0;
      stk_we  = 1'b0; stk_wa  = '0; stk_wd  = '0; stk_ra  = '0;
      min_a   = cur_low_ff;
      min_b   = cur_disc_ff;

      unique case (state_ff)
         bcl_pkg::S_IDLE: begin
            if (req_valid) begin
               a_in    = req_data.vertex_a;
               b_in    = req_data.vertex_b;
               ans_in  = '0;
               stat_in = bcl_pkg::ST_OK;
               unique case (req_data.cmd)
                  bcl_pkg::CMD_CLEAR: begin
                     hv_in    = '0;
                     cnt_in   = '0;
                     state_in = bcl_pkg::S_DONE;
                  end
                  bcl_pkg::CMD_ADD: begin
                     side_in = 1'b0;
                     if (bad_a || bad_b) begin
                        stat_in  = bcl_pkg::ST_RANGE;
                        state_in = bcl_pkg::S_DONE;
                     end else if (full) begin
                        stat_in  = bcl_pkg::ST_FULL;
                        state_in = bcl_pkg::S_DONE;
                     end else begin
                        state_in = bcl_pkg::S_ADD_RD;
                     end
                  end
                  bcl_pkg::CMD_RUN: begin
                     sweep_in = '0;
                     state_in = bcl_pkg::S_RUN_CLR;
                  end
                  bcl_pkg::CMD_QUERY: begin
                     lab_ra = req_data.vertex_a;
                     if (bad_a) begin
                        stat_in  = bcl_pkg::ST_RANGE;
                        state_in = bcl_pkg::S_DONE;
                     end else begin
                        state_in = bcl_pkg::S_QRY;
                     end
                  end
                  default: state_in = bcl_pkg::S_IDLE;
               endcase
            end
         end
         bcl_pkg::S_ADD_RD: begin
            // new entry goes to the tail; its link starts empty
            tail_ra  = owner;
            nbr_we   = 1'b1;
            nbr_wa   = cnt_ff[ENTRY_W-1:0];
            nbr_wd   = other;
            nxt_we   = 1'b1;
            nxt_wa   = cnt_ff[ENTRY_W-1:0];
            nxt_wd   = NIL;
            state_in = bcl_pkg::S_ADD_WR;
         end
         bcl_pkg::S_ADD_WR: begin
            if (hv_ff[owner]) begin
               nxt_we = 1'b1;
               nxt_wa = tail_rd_ff;
               nxt_wd = {1'b0, cnt_ff[ENTRY_W-1:0]};
            end else begin
               head_we      = 1'b1;
               head_wa      = owner;
               head_wd      = cnt_ff[ENTRY_W-1:0];
               hv_in[owner] = 1'b1;
            end
            tail_we = 1'b1;
            tail_wa = owner;
            tail_wd = cnt_ff[ENTRY_W-1:0];
            cnt_in  = cnt_ff + CNT_W'(1);
            if (side_ff) begin
               state_in = bcl_pkg::S_DONE;
            end else begin
               side_in  = 1'b1;
               state_in = bcl_pkg::S_ADD_RD;
            end
         end
         bcl_pkg::S_QRY: begin
            ans_in   = ran_ff ? lab_rd_ff : '0;
            state_in = bcl_pkg::S_DONE;
         end
         bcl_pkg::S_RUN_CLR: begin
            disc_we = 1'b1;
            disc_wa = sweep_ff;
            disc_wd = '0;
            lab_we  = 1'b1;
            lab_wa  = sweep_ff;
            lab_wd  = '0;
            if (sweep_ff == VW'(bcl_pkg::MAX_VERTS)) begin
               state_in = bcl_pkg::S_RUN_INIT;
            end else begin
               sweep_in = sweep_ff + VW'(1);
            end
         end
         bcl_pkg::S_RUN_INIT: begin
            head_ra     = VW'(1);
            disc_we     = 1'b1;
            disc_wa     = VW'(1);
            disc_wd     = VW'(1);
            pend_we     = 1'b1;
            pend_wa     = '0;
            pend_wd     = VW'(1);
            pend_in     = VW'(1);
            time_in     = VW'(1);
            comp_in     = '0;
            depth_in    = VW'(1);
            cur_v_in    = VW'(1);
            cur_par_in  = '0;
            cur_low_in  = VW'(1);
            cur_disc_in = VW'(1);
            cur_pidx_in = '0;
            ran_in      = 1'b1;
            state_in    = bcl_pkg::S_RUN_HEAD;
         end
         bcl_pkg::S_RUN_HEAD: begin
            cur_cur_in = hv_ff[cur_v_ff] ? {1'b0, head_rd_ff} : NIL;
            state_in   = bcl_pkg::S_LOOP;
         end
         bcl_pkg::S_LOOP: begin
            if (cur_cur_ff[ENTRY_W]) begin
               state_in = bcl_pkg::S_FINISH;
            end else begin
               state_in = bcl_pkg::S_NBR;
            end
         end
         bcl_pkg::S_NBR: begin
            nb_in      = nbr_rd_ff;
            cur_cur_in = nxt_rd_ff;
            disc_ra    = nbr_rd_ff;
            // skip the edge back to the parent vertex
            if (nbr_rd_ff == cur_par_ff) begin
               state_in = bcl_pkg::S_LOOP;
            end else begin
               state_in = bcl_pkg::S_CHK;
            end
         end
         bcl_pkg::S_CHK: begin
            min_b = disc_rd_ff;
            if (disc_rd_ff == '0) begin
               time_in     = time_ff + VW'(1);
               disc_we     = 1'b1;
               disc_wa     = nb_ff;
               disc_wd     = time_ff + VW'(1);
               pend_we     = 1'b1;
               pend_wa     = pend_ff[SW-1:0];
               pend_wd     = nb_ff;
               pend_in     = pend_ff + VW'(1);
               stk_we      = 1'b1;
               stk_wa      = SW'(depth_ff - VW'(1));
               stk_wd      = '{v: cur_v_ff, par: cur_par_ff, cursor: cur_cur_ff,
                               low: cur_low_ff, disc: cur_disc_ff, pidx: cur_pidx_ff};
               depth_in    = depth_ff + VW'(1);
               cur_v_in    = nb_ff;
               cur_par_in  = cur_v_ff;
               cur_low_in  = time_ff + VW'(1);
               cur_disc_in = time_ff + VW'(1);
               cur_pidx_in = pend_ff;
               head_ra     = nb_ff;
               state_in    = bcl_pkg::S_RUN_HEAD;
            end else begin
               cur_low_in = min_val;
               state_in   = bcl_pkg::S_LOOP;
            end
         end
         bcl_pkg::S_FINISH: begin
            if (min_eq) begin
               comp_in  = comp_ff + VW'(1);
               state_in = bcl_pkg::S_POP_RD;
            end else begin
               state_in = bcl_pkg::S_RET;
            end
         end
         bcl_pkg::S_POP_RD: begin
            pend_ra  = SW'(pend_ff - VW'(1));
            pend_in  = pend_ff - VW'(1);
            state_in = bcl_pkg::S_POP_WR;
         end
         bcl_pkg::S_POP_WR: begin
            lab_we = 1'b1;
            lab_wa = pend_rd_ff;
            lab_wd = comp_ff;
            // stop once the finishing vertex itself is labeled
            if (pend_ff == cur_pidx_ff) begin
               state_in = bcl_pkg::S_RET;
            end else begin
               state_in = bcl_pkg::S_POP_RD;
            end
         end
         bcl_pkg::S_RET: begin
            depth_in = depth_ff - VW'(1);
            stk_ra   = SW'(depth_ff - VW'(2));
            if (depth_ff == VW'(1)) begin
               ans_in   = comp_ff;
               state_in = bcl_pkg::S_DONE;
            end else begin
               state_in = bcl_pkg::S_RET_WAIT;
            end
         end
         bcl_pkg::S_RET_WAIT: begin
            // fold the child's low stamp into the parent
            min_a       = stk_rd_ff.low;
            min_b       = cur_low_ff;
            cur_v_in    = stk_rd_ff.v;
            cur_par_in  = stk_rd_ff.par;
            cur_cur_in  = stk_rd_ff.cursor;
            cur_disc_in = stk_rd_ff.disc;
            cur_pidx_in = stk_rd_ff.pidx;
            cur_low_in  = min_val;
            state_in    = bcl_pkg::S_LOOP;
         end
         bcl_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.answer = ans_ff;
               rsp_data_in.status = stat_ff;
               state_in           = bcl_pkg::S_IDLE;
            end
         end
         default: state_in = bcl_pkg::S_IDLE;
      endcase
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= VW'(bcl_pkg::MAX_VERTS))
      else $error("walk depth beyond vertex store");

   a_time_bound: assert property (@(posedge clock) disable iff (reset)
      time_ff <= VW'(bcl_pkg::MAX_VERTS))
      else $error("time counter beyond vertex store");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcl_pkg::S_IDLE) |-> (depth_ff == '0))
      else $error("walk stack not empty in idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bcl_pkg::S_DONE))
      else $error("response raised outside done");

endmodule

>>> rtl/bcl_min_unit.sv
`timescale 1ns / 1ps
module bcl_min_unit (
   input  logic [bcl_pkg::VERT_W-1:0] op_a,
   input  logic [bcl_pkg::VERT_W-1:0] op_b,
   output logic [bcl_pkg::VERT_W-1:0] min_val,
   output logic                       eq
);

   assign min_val = (op_b < op_a) ? op_b : op_a;
   assign eq      = (op_a == op_b);

endmodule

>>> tb/bridge_component_labeler_tb.sv
`timescale 1ns / 1ps
module bridge_component_labeler_tb;

   localparam int unsigned EDGE_LIMIT = 1024;
   localparam int unsigned SLOTS = 2 * EDGE_LIMIT;
   localparam int unsigned NIL = 32'hFFFF_FFFF;
   localparam int unsigned IDLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bcl_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bcl_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bridge_component_labeler DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mirror of the labeler state
   int unsigned vc_reg;
   int unsigned nbr_mem [SLOTS];
   int unsigned nxt_mem [SLOTS];
   int unsigned head_mem [bcl_pkg::VSLOTS];
   int unsigned tail_mem [bcl_pkg::VSLOTS];
   int unsigned entries;
   int unsigned disc [bcl_pkg::VSLOTS];
   int unsigned lowv [bcl_pkg::VSLOTS];
   int unsigned label_of [bcl_pkg::VSLOTS];
   int unsigned comp_total;

   bcl_pkg::rsp_type expected_rsps [$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;
   bit req_on = 1'b0;

   function automatic void wipe_graph();
      for (int v = 0; v < bcl_pkg::VSLOTS; v++) begin
         head_mem[v] = NIL;
         tail_mem[v] = NIL;
      end
      entries = 0;
   endfunction

   function automatic void link_entry(int unsigned owner, int unsigned other);
      nbr_mem[entries] = other;
      nxt_mem[entries] = NIL;
      if (tail_mem[owner] == NIL) head_mem[owner] = entries;
      else nxt_mem[tail_mem[owner]] = entries;
      tail_mem[owner] = entries;
      entries++;
   endfunction

   function automatic void label_bridges();
      int unsigned fv [bcl_pkg::VSLOTS];
      int unsigned fp [bcl_pkg::VSLOTS];
      int unsigned fc [bcl_pkg::VSLOTS];
      int unsigned pend_q [bcl_pkg::VSLOTS];
      int unsigned depth, pend, clk, v, nb, w, p;
      depth = 0;
      pend = 0;
      clk = 1;
      for (int i = 0; i < bcl_pkg::VSLOTS; i++) begin
         disc[i] = 0;
         lowv[i] = 0;
         label_of[i] = 0;
      end
      comp_total = 0;
      disc[1] = 1;
      lowv[1] = 1;
      pend_q[pend++] = 1;
      fv[0] = 1;
      fp[0] = 0;
      fc[0] = head_mem[1];
      depth = 1;
      while (depth > 0) begin
         v = fv[depth-1];
         if (fc[depth-1] != NIL && fc[depth-1] < SLOTS) begin
            nb = nbr_mem[fc[depth-1]];
            fc[depth-1] = nxt_mem[fc[depth-1]];
            if (nb >= bcl_pkg::VSLOTS || nb == fp[depth-1]) continue;
            if (disc[nb] == 0) begin
               if (depth >= bcl_pkg::VSLOTS || pend >= bcl_pkg::VSLOTS) continue;
               clk++;
               disc[nb] = clk;
               lowv[nb] = clk;
               pend_q[pend++] = nb;
               fv[depth] = nb;
               fp[depth] = v;
               fc[depth] = head_mem[nb];
               depth++;
            end else if (disc[nb] < lowv[v]) begin
               lowv[v] = disc[nb];
            end
         end else begin
            if (lowv[v] == disc[v]) begin
               comp_total++;
               while (pend > 0) begin
                  pend--;
                  w = pend_q[pend];
                  label_of[w] = comp_total;
                  if (w == v) break;
               end
            end
            depth--;
            if (depth > 0) begin
               p = fv[depth-1];
               if (lowv[v] < lowv[p]) lowv[p] = lowv[v];
            end
         end
      end
   endfunction

   function automatic bcl_pkg::rsp_type predict_labeler(bcl_pkg::req_type r);
      bcl_pkg::rsp_type o;
      int unsigned n;
      o = '0;
      n = (vc_reg == 0) ? 1 :
          (vc_reg > bcl_pkg::MAX_VERTS ? bcl_pkg::MAX_VERTS : vc_reg);
      case (r.cmd)
         bcl_pkg::CMD_CLEAR: wipe_graph();
         bcl_pkg::CMD_ADD: begin
            if (r.vertex_a == 0 || r.vertex_a > n || r.vertex_b == 0 || r.vertex_b > n)
               o.status = bcl_pkg::ST_RANGE;
            else if (entries > SLOTS - 2) o.status = bcl_pkg::ST_FULL;
            else begin
               link_entry(r.vertex_a, r.vertex_b);
               link_entry(r.vertex_b, r.vertex_a);
            end
         end
         bcl_pkg::CMD_RUN: begin
            label_bridges();
            o.answer = comp_total[8:0];
         end
         default: begin
            if (r.vertex_a == 0 || r.vertex_a > n) o.status = bcl_pkg::ST_RANGE;
            else o.answer = label_of[r.vertex_a][8:0];
         end
      endcase
      return o;
   endfunction

   // drop valid and step past the edge so the next drive lands in a later step
   task automatic drop_valid();
      if (req_on) begin
         req_valid <= 1'b0;
         req_on = 1'b0;
         @(posedge clock);
      end
   endtask

   // hand one word to the block; optional typed-in answer is checked too
   task automatic send_word(bcl_pkg::req_type r, bit has_fixed = 1'b0,
                            bcl_pkg::rsp_type fixed = '0);
      bcl_pkg::rsp_type p;
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         drop_valid();
         repeat (gap) @(posedge clock);
      end
      p = predict_labeler(r);
      if (has_fixed && p.answer !== fixed.answer) begin
         $error("answer: expected %0d, model %0d", fixed.answer, p.answer);
         errors++;
      end
      if (has_fixed && p.status !== fixed.status) begin
         $error("status: expected %0d, model %0d", fixed.status, p.status);
         errors++;
      end
      expected_rsps.insert(expected_rsps.size(), p);
      req_data <= r;
      req_valid <= 1'b1;
      req_on = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_vertex_count(int unsigned value);
      wait_drained();
      repeat (3) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= bcl_pkg::REG_VC_ADDR;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      vc_reg = value & 32'h1FF;
   endtask

   function automatic bcl_pkg::req_type mk(logic [1:0] c, int unsigned a, int unsigned b);
      bcl_pkg::req_type r;
      r.cmd = c;
      r.vertex_a = a[8:0];
      r.vertex_b = b[8:0];
      return r;
   endfunction

   // random graph phase: mostly sensible edges, a run, then queries
   task automatic graph_phase(int unsigned nv, int unsigned words);
      int unsigned k;
      k = 0;
      send_word(mk(bcl_pkg::CMD_CLEAR, $urandom, $urandom));
      while (k < words) begin
         int unsigned pick;
         pick = $urandom_range(0, 99);
         if (pick < 55)
            send_word(mk(bcl_pkg::CMD_ADD, $urandom_range(1, nv), $urandom_range(1, nv)));
         else if (pick < 60)
            send_word(mk(bcl_pkg::CMD_ADD, $urandom_range(0, 511), $urandom_range(0, 511)));
         else if (pick < 66) send_word(mk(bcl_pkg::CMD_RUN, $urandom, $urandom));
         else if (pick < 68) send_word(mk(bcl_pkg::CMD_CLEAR, $urandom, $urandom));
         else if (pick < 95)
            send_word(mk(bcl_pkg::CMD_QUERY, $urandom_range(0, nv + 1), $urandom));
         else send_word(mk(bcl_pkg::CMD_QUERY, $urandom_range(0, 511), $urandom));
         k++;
      end
      send_word(mk(bcl_pkg::CMD_RUN, 0, 0));
      for (int v = 0; v <= nv && v < 40; v++) send_word(mk(bcl_pkg::CMD_QUERY, v, $urandom));
   endtask

   typedef struct {
      bcl_pkg::req_type r;
      bit fixed;
      bcl_pkg::rsp_type o;
   } table_row;

   table_row stim_table [$];

   function automatic table_row row(logic [1:0] c, int unsigned a, int unsigned b,
                                    bit f = 1'b0, int unsigned ans = 0,
                                    logic [1:0] st = bcl_pkg::ST_OK);
      table_row t;
      t.r = mk(c, a, b);
      t.fixed = f;
      t.o.answer = ans[8:0];
      t.o.status = st;
      return t;
   endfunction

   function automatic void put_row(table_row t);
      stim_table.insert(stim_table.size(), t);
   endfunction

   // response side: random stall, check in order
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected word: answer %0d status %0d", rsp_data.answer,
                      rsp_data.status);
               errors++;
            end else begin
               bcl_pkg::rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data.answer !== e.answer) begin
                  $error("answer: expected %0d, got %0d", e.answer, rsp_data.answer);
                  errors++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 19) == 0) rsp_stall <= ($urandom_range(0, 3) == 0);
         else if ($urandom_range(0, 2) == 0) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 6) == 0) rsp_stall <= 1'b1;
      end
   end

   // watchdog on accepted words
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && (!stim_done || expected_rsps.size() != 0)) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      vc_reg = 256;
      wipe_graph();
      for (int i = 0; i < bcl_pkg::VSLOTS; i++) label_of[i] = 0;
      comp_total = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: reset labels, range errors, triangle plus bridge, self loop
      put_row(row(bcl_pkg::CMD_QUERY, 1, 0, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_QUERY, 256, 511, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_QUERY, 0, 0, 1, 0, bcl_pkg::ST_RANGE));
      put_row(row(bcl_pkg::CMD_QUERY, 511, 0, 1, 0, bcl_pkg::ST_RANGE));
      put_row(row(bcl_pkg::CMD_ADD, 0, 5, 1, 0, bcl_pkg::ST_RANGE));
      put_row(row(bcl_pkg::CMD_ADD, 5, 257, 1, 0, bcl_pkg::ST_RANGE));
      put_row(row(bcl_pkg::CMD_ADD, 1, 2, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_ADD, 2, 3, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_ADD, 3, 1, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_ADD, 3, 256, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_ADD, 256, 256, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_ADD, 1, 2, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_RUN, 0, 0, 1, 2, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_QUERY, 1, 0));
      put_row(row(bcl_pkg::CMD_QUERY, 3, 0));
      put_row(row(bcl_pkg::CMD_QUERY, 256, 0));
      put_row(row(bcl_pkg::CMD_QUERY, 4, 0, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_CLEAR, 511, 511, 1, 0, bcl_pkg::ST_OK));
      put_row(row(bcl_pkg::CMD_QUERY, 256, 0));
      put_row(row(bcl_pkg::CMD_RUN, 0, 0, 1, 1, bcl_pkg::ST_OK));
      foreach (stim_table[i]) send_word(stim_table[i].r, stim_table[i].fixed, stim_table[i].o);

      // fill the edge store to the brim
      write_vertex_count(2);
      send_word(mk(bcl_pkg::CMD_CLEAR, 0, 0));
      for (int i = 0; i < EDGE_LIMIT; i++) send_word(mk(bcl_pkg::CMD_ADD, 1 + i % 2, 2));
      send_word(mk(bcl_pkg::CMD_ADD, 1, 2), 1'b1, '{answer: 9'd0, status: bcl_pkg::ST_FULL});
      send_word(mk(bcl_pkg::CMD_ADD, 3, 2), 1'b1, '{answer: 9'd0, status: bcl_pkg::ST_RANGE});
      send_word(mk(bcl_pkg::CMD_RUN, 0, 0));
      send_word(mk(bcl_pkg::CMD_QUERY, 2, 0));

      // vertex count 0 acts as 1; shrunk count keeps stored edges
      write_vertex_count(0);
      send_word(mk(bcl_pkg::CMD_QUERY, 2, 0), 1'b1,
                '{answer: 9'd0, status: bcl_pkg::ST_RANGE});
      send_word(mk(bcl_pkg::CMD_RUN, 0, 0));
      send_word(mk(bcl_pkg::CMD_QUERY, 1, 0));
      write_vertex_count(511);
      graph_phase(256, 60);
      write_vertex_count(256);
      graph_phase(256, 50);

      // random part: small graphs mostly
      for (int ph = 0; ph < 5; ph++) begin
         int unsigned nv;
         nv = (ph % 5 == 4) ? 256 : $urandom_range(2, 24);
         write_vertex_count(nv);
         graph_phase(nv, 40);
         if (ph == 2) wait_drained();
      end
      write_vertex_count(1);
      graph_phase(1, 30);

      stim_done = 1'b1;
      wait_drained();
      repeat (600) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> bridge_component_labeler.f
rtl/bcl_pkg.sv
rtl/bcl_min_unit.sv
rtl/bridge_component_labeler.sv
tb/bridge_component_labeler_tb.sv
